### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks clocked on clk, held off while arst_n is low.
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define CHK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/skt_pkg.sv
package skt_pkg;

	localparam int DEPTH_DEF    = 64;
	localparam int KEY_BITS_DEF = 32;

	localparam int OP_W    = 2;
	localparam int KEY_W   = 32;
	localparam int SCORE_W = 16;
	localparam int ST_W    = 2;
	localparam int REC_W   = 3 * SCORE_W;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_DUP     = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

	localparam int IN_BITS    = OP_W + KEY_W + REC_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic load;
		logic srch_rd;
		logic srch_cmp;
		logic probe_rd;
		logic probe_chk;
		logic shift_ins;
		logic shift_del;
		logic shift_step;
		logic write_new;
		logic finish;
	} skt_cmd_t;

	typedef struct packed {
		logic            srch_done;
		logic            hit;
		logic            full;
		logic            ins_move;
		logic            del_move;
		logic            shift_busy;
		logic            out_free;
		logic [OP_W-1:0] op;
	} skt_stat_t;

endpackage

### hdl/skt_ram.sv
module skt_ram
	import skt_pkg::*;
#(
	parameter int WIDTH = REC_W + KEY_BITS_DEF,
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/skt_datapath.sv
module skt_datapath
	import skt_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  skt_cmd_t           cmd,
	output skt_stat_t          stat,
	input  logic [OP_W-1:0]    operation,
	input  logic [KEY_W-1:0]   key,
	input  logic [SCORE_W-1:0] score_a,
	input  logic [SCORE_W-1:0] score_b,
	input  logic [SCORE_W-1:0] score_c,
	input  logic               m_ready,
	output logic               m_valid,
	output logic [ST_W-1:0]    status,
	output logic [AW-1:0]      position,
	output logic [CW-1:0]      occupancy,
	output logic [SCORE_W-1:0] found_a,
	output logic [SCORE_W-1:0] found_b,
	output logic [SCORE_W-1:0] found_c,
	output logic [CW-1:0]      entry_count
);

	localparam int RW = KEY_BITS + REC_W;

	logic [KEY_W+KEY_BITS-1:0] key_ext;
	logic [OP_W-1:0]           op_q;
	logic [KEY_BITS-1:0]       key_q;
	logic [REC_W-1:0]          rec_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             lo_q;
	logic [CW-1:0]             hi_q;
	logic                      hit_q;
	logic [REC_W-1:0]          found_q;
	logic [AW-1:0]             rd_q;
	logic [AW-1:0]             last_q;
	logic [AW-1:0]             pend_addr_q;
	logic                      rd_act_q;
	logic                      pend_q;

	logic                      out_valid_q;
	logic [ST_W-1:0]           out_status_q;
	logic [AW-1:0]             out_pos_q;
	logic [CW-1:0]             out_occ_q;
	logic [REC_W-1:0]          out_found_q;

	logic [CW:0]               mid_sum;
	logic [CW-1:0]             mid;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [RW-1:0]             ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic [RW-1:0]             ram_rdata;
	logic [KEY_BITS-1:0]       mem_key;
	logic                      hit_now;

	logic [ST_W-1:0]           res_status;
	logic [AW-1:0]             res_pos;
	logic [CW-1:0]             res_count;
	logic [REC_W-1:0]          res_found;

	assign key_ext = {{KEY_BITS{1'b0}}, key};
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign mem_key = ram_rdata[KEY_BITS-1:0];
	assign hit_now = (lo_q < count_q) && (mem_key == key_q);

	assign stat.srch_done  = (lo_q == hi_q);
	assign stat.hit        = hit_now;
	assign stat.full       = (count_q == CW'(DEPTH));
	assign stat.ins_move   = (count_q > lo_q);
	assign stat.del_move   = (({1'b0, lo_q} + (CW+1)'(1)) < {1'b0, count_q});
	assign stat.shift_busy = rd_act_q | pend_q;
	assign stat.out_free   = !out_valid_q || m_ready;
	assign stat.op         = op_q;

	always_comb begin
		ram_raddr = rd_q;
		if (cmd.srch_rd) begin
			ram_raddr = mid[AW-1:0];
		end else if (cmd.probe_rd) begin
			ram_raddr = lo_q[AW-1:0];
		end
	end

	assign ram_we    = pend_q | cmd.write_new;
	assign ram_waddr = pend_q ? pend_addr_q : lo_q[AW-1:0];
	assign ram_wdata = pend_q ? ram_rdata : {rec_q, key_q};

	skt_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			key_q <= key_ext[KEY_BITS-1:0];
			rec_q <= {score_c, score_b, score_a};
		end
		if (cmd.probe_chk) begin
			hit_q   <= hit_now;
			found_q <= ram_rdata[KEY_BITS +: REC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (cmd.load) begin
			lo_q <= '0;
			hi_q <= count_q;
		end else if (cmd.srch_cmp) begin
			if (mem_key < key_q) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end
	end

	// shift engine: read one slot per cycle, write it one slot over in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q    <= 1'b0;
			pend_q      <= 1'b0;
			rd_q        <= '0;
			last_q      <= '0;
			pend_addr_q <= '0;
		end else if (cmd.shift_ins) begin
			rd_q     <= AW'(count_q - CW'(1));
			last_q   <= lo_q[AW-1:0];
			rd_act_q <= 1'b1;
		end else if (cmd.shift_del) begin
			rd_q     <= AW'(lo_q + CW'(1));
			last_q   <= AW'(count_q - CW'(1));
			rd_act_q <= 1'b1;
		end else if (cmd.shift_step) begin
			pend_q <= rd_act_q;
			if (op_q == OP_INSERT) begin
				pend_addr_q <= rd_q + AW'(1);
			end else begin
				pend_addr_q <= rd_q - AW'(1);
			end
			if (rd_act_q) begin
				if (rd_q == last_q) begin
					rd_act_q <= 1'b0;
				end else if (op_q == OP_INSERT) begin
					rd_q <= rd_q - AW'(1);
				end else begin
					rd_q <= rd_q + AW'(1);
				end
			end
		end
	end

	always_comb begin
		res_status = ST_OK;
		res_pos    = '0;
		res_count  = count_q;
		res_found  = '0;
		unique case (op_q)
			OP_INSERT: begin
				if (hit_q) begin
					res_status = ST_DUP;
					res_pos    = lo_q[AW-1:0];
				end else if (count_q == CW'(DEPTH)) begin
					res_status = ST_FULL;
				end else begin
					res_pos   = lo_q[AW-1:0];
					res_count = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (!hit_q) begin
					res_status = ST_MISSING;
				end else begin
					res_pos   = lo_q[AW-1:0];
					res_count = count_q - CW'(1);
				end
			end
			OP_FIND: begin
				if (!hit_q) begin
					res_status = ST_MISSING;
				end else begin
					res_pos   = lo_q[AW-1:0];
					res_found = found_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			count_q     <= res_count;
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status_q <= res_status;
			out_pos_q    <= res_pos;
			out_occ_q    <= res_count;
			out_found_q  <= res_found;
		end
	end

	assign m_valid     = out_valid_q;
	assign status      = out_status_q;
	assign position    = out_pos_q;
	assign occupancy   = out_occ_q;
	assign found_a     = out_found_q[SCORE_W-1:0];
	assign found_b     = out_found_q[2*SCORE_W-1:SCORE_W];
	assign found_c     = out_found_q[3*SCORE_W-1:2*SCORE_W];
	assign entry_count = count_q;

endmodule

### hdl/skt_ctrl.sv
module skt_ctrl
	import skt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_valid,
	output logic      s_ready,
	input  skt_stat_t stat,
	output skt_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_SCMP  = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_WNEW  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SRCH;
				end
			end
			S_SRCH: begin
				if (stat.srch_done) begin
					cmd.probe_rd = 1'b1;
					state_d      = S_CHK;
				end else begin
					cmd.srch_rd = 1'b1;
					state_d     = S_SCMP;
				end
			end
			S_SCMP: begin
				cmd.srch_cmp = 1'b1;
				state_d      = S_SRCH;
			end
			S_CHK: begin
				cmd.probe_chk = 1'b1;
				state_d       = S_DONE;
				unique case (stat.op)
					OP_INSERT: begin
						if (!stat.hit && !stat.full) begin
							if (stat.ins_move) begin
								cmd.shift_ins = 1'b1;
								state_d       = S_SHIFT;
							end else begin
								state_d = S_WNEW;
							end
						end
					end
					OP_DELETE: begin
						if (stat.hit && stat.del_move) begin
							cmd.shift_del = 1'b1;
							state_d       = S_SHIFT;
						end
					end
					default: begin
					end
				endcase
			end
			S_SHIFT: begin
				if (stat.shift_busy) begin
					cmd.shift_step = 1'b1;
				end else if (stat.op == OP_INSERT) begin
					state_d = S_WNEW;
				end else begin
					state_d = S_DONE;
				end
			end
			S_WNEW: begin
				cmd.write_new = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/sorted_key_table.sv
// Sorted key table: up to DEPTH records held in ascending key order, each with
// three 16-bit scores. Operations arrive on the s_axis channel (insert, delete
// by key, find by key) and each produces exactly one result transaction on
// m_axis (status, position, occupancy, found scores).
// One operation is worked at a time. A binary search over the stored keys runs
// in halving steps of one RAM read and one compare, then one more probe read.
// Insert and delete then move every later record by one slot through the
// single-port-read record RAM, one record per cycle. s_axis_tready returns
// together with m_axis_tvalid, so the next operation is accepted only after
// the result of the last one is registered.
// s_axis_tready is high whenever no operation is in progress; the result sits
// in an output register, so the next operation can be taken and worked while
// the receiver stalls. A finished result waits until that register is free.
// Reset empties the table (occupancy zero) and drops any pending result; the
// RAM contents are not cleared, as data from slots at or above the occupancy is never used.
`include "assert_macros.svh"

module sorted_key_table
	import skt_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	localparam int POS_W       = $clog2(DEPTH),
	localparam int OCC_W       = $clog2(DEPTH + 1),
	localparam int OUT_BITS    = ST_W + POS_W + OCC_W + REC_W,
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// operation, key, score_a, score_b, score_c, zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// status, position, occupancy, found_a, found_b, found_c, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	skt_cmd_t           cmd;
	skt_stat_t          stat;
	logic [OP_W-1:0]    operation;
	logic [KEY_W-1:0]   key;
	logic [SCORE_W-1:0] score_a;
	logic [SCORE_W-1:0] score_b;
	logic [SCORE_W-1:0] score_c;
	logic [ST_W-1:0]    status;
	logic [POS_W-1:0]   position;
	logic [OCC_W-1:0]   occupancy;
	logic [SCORE_W-1:0] found_a;
	logic [SCORE_W-1:0] found_b;
	logic [SCORE_W-1:0] found_c;
	logic [OCC_W-1:0]   entry_count;

	assign operation = s_axis_tdata[OP_W-1:0];
	assign key       = s_axis_tdata[OP_W +: KEY_W];
	assign score_a   = s_axis_tdata[OP_W+KEY_W +: SCORE_W];
	assign score_b   = s_axis_tdata[OP_W+KEY_W+SCORE_W +: SCORE_W];
	assign score_c   = s_axis_tdata[OP_W+KEY_W+2*SCORE_W +: SCORE_W];

	assign m_axis_tdata = OUT_TDATA_W'({found_c, found_b, found_a, occupancy, position, status});

	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.stat   (stat),
		.cmd    (cmd)
	);

	skt_datapath #(
		.DEPTH   (DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.operation  (operation),
		.key        (key),
		.score_a    (score_a),
		.score_b    (score_b),
		.score_c    (score_c),
		.m_ready    (m_axis_tready),
		.m_valid    (m_axis_tvalid),
		.status     (status),
		.position   (position),
		.occupancy  (occupancy),
		.found_a    (found_a),
		.found_b    (found_b),
		.found_c    (found_c),
		.entry_count(entry_count)
	);

	`CHK_ALWAYS(a_occ_bound, entry_count <= OCC_W'(DEPTH), "occupancy exceeds table depth")
	`CHK_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"second op taken while busy")
	`CHK_SAME(a_count_on_result, !$stable(entry_count),
		m_axis_tvalid && occupancy == entry_count, "occupancy changed without a result")
	`CHK_SAME(a_found_zero, m_axis_tvalid && status != ST_OK,
		found_a == '0 && found_b == '0 && found_c == '0, "scores on failed op")

endmodule

### test/sorted_key_table_test.sv
`timescale 1ns / 1ps

module sorted_key_table_test;
	import skt_pkg::*;

	localparam int SLOTS = DEPTH_DEF;
	localparam int RES_W = 64;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 120;

	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [5:0]         position;
		logic [6:0]         occupancy;
		logic [SCORE_W-1:0] found_a;
		logic [SCORE_W-1:0] found_b;
		logic [SCORE_W-1:0] found_c;
	} table_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [RES_W-1:0]      m_axis_tdata;

	// shadow table
	logic [KEY_W-1:0] held_keys [SLOTS];
	logic [REC_W-1:0] held_scores [SLOTS];
	int               held_count = 0;

	table_result_t pending_results[$];
	table_result_t want_res;
	table_result_t got_res;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	logic hold_rx = 1'b0;
	int  quiet_cycles = 0;
	int  errors = 0;
	int  bad_fields;
	int  ops_sent = 0;
	int  results_seen = 0;
	int  peak_count = 0;
	int  n_full = 0;
	int  n_dup = 0;
	int  n_missing = 0;
	int  n_found = 0;
	int  n_unused = 0;

	sorted_key_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic table_result_t apply_table_op(logic [OP_W-1:0] op,
			logic [KEY_W-1:0] key, logic [REC_W-1:0] rec);
		table_result_t r;
		int slot;
		int j;
		bit hit;
		r = '0;
		slot = 0;
		while (slot < held_count && held_keys[slot] < key)
			slot++;
		hit = (slot < held_count) && (held_keys[slot] == key);
		case (op)
			OP_INSERT: begin
				if (hit) begin
					r.status = ST_DUP;
					r.position = 6'(slot);
					n_dup++;
				end else if (held_count >= SLOTS) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					for (j = held_count; j > slot; j--) begin
						held_keys[j] = held_keys[j - 1];
						held_scores[j] = held_scores[j - 1];
					end
					held_keys[slot] = key;
					held_scores[slot] = rec;
					held_count++;
					r.position = 6'(slot);
				end
			end
			OP_DELETE: begin
				if (!hit) begin
					r.status = ST_MISSING;
					n_missing++;
				end else begin
					for (j = slot; j + 1 < held_count; j++) begin
						held_keys[j] = held_keys[j + 1];
						held_scores[j] = held_scores[j + 1];
					end
					held_count--;
					r.position = 6'(slot);
				end
			end
			OP_FIND: begin
				if (!hit) begin
					r.status = ST_MISSING;
					n_missing++;
				end else begin
					r.position = 6'(slot);
					r.found_a = held_scores[slot][15:0];
					r.found_b = held_scores[slot][31:16];
					r.found_c = held_scores[slot][47:32];
					n_found++;
				end
			end
			default: begin
				n_unused++;
			end
		endcase
		r.occupancy = 7'(held_count);
		if (held_count > peak_count)
			peak_count = held_count;
		return r;
	endfunction

	function automatic int field_bad(string name, logic [15:0] want, logic [15:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		return 1;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending, actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want_res = pending_results.pop_front();
				got_res.status = m_axis_tdata[1:0];
				got_res.position = m_axis_tdata[7:2];
				got_res.occupancy = m_axis_tdata[14:8];
				got_res.found_a = m_axis_tdata[30:15];
				got_res.found_b = m_axis_tdata[46:31];
				got_res.found_c = m_axis_tdata[62:47];
				bad_fields = field_bad("status", want_res.status, got_res.status)
					+ field_bad("position", want_res.position, got_res.position)
					+ field_bad("occupancy", want_res.occupancy, got_res.occupancy)
					+ field_bad("found_a", want_res.found_a, got_res.found_a)
					+ field_bad("found_b", want_res.found_b, got_res.found_b)
					+ field_bad("found_c", want_res.found_c, got_res.found_c);
				if (bad_fields != 0)
					errors++;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_rx)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [SCORE_W-1:0] a, input logic [SCORE_W-1:0] b,
			input logic [SCORE_W-1:0] c);
		s_axis_tdata <= IN_TDATA_W'({c, b, a, key, op});
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_table_op(op, key, {c, b, a}));
		ops_sent++;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
	endtask

	task automatic wait_drained;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct <= recv_pct;
	endtask

	function automatic logic [KEY_W-1:0] pick_key(int reuse_pct);
		int r;
		logic [KEY_W-1:0] k;
		r = $urandom_range(0, 99);
		if (held_count > 0 && r < reuse_pct + 15) begin
			k = held_keys[$urandom_range(0, held_count - 1)];
			if (r < reuse_pct)
				return k;
			return $urandom_range(0, 1) ? k + 1 : k - 1;
		end
		if (r < reuse_pct + 25) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return 32'd1;
				2: return '1;
				default: return 32'hFFFF_FFFE;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [OP_W-1:0] pick_op(int ins_pct, int del_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			return OP_INSERT;
		if (r < ins_pct + del_pct)
			return OP_DELETE;
		if (r < 97)
			return OP_FIND;
		return OP_UNUSED;
	endfunction

	task automatic run_phase(input int count, input int ins_pct, input int del_pct,
			input int reuse_pct);
		repeat (count)
			send_op(pick_op(ins_pct, del_pct), pick_key(reuse_pct),
				16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic test_directed;
		set_idling(0, 0);
		send_op(OP_FIND, '0, '0, '0, '0);
		send_op(OP_DELETE, '1, '0, '0, '0);
		send_op(OP_UNUSED, '1, '1, '1, '1);
		send_op(OP_INSERT, '1, '1, '1, '1);
		send_op(OP_INSERT, '0, '0, '0, '0);
		send_op(OP_INSERT, 32'h8000_0000, 16'h8000, 16'h00FF, 16'hFF00);
		send_op(OP_INSERT, 32'h7FFF_FFFF, 16'h5555, 16'hAAAA, 16'h0001);
		send_op(OP_INSERT, '1, 16'h1234, 16'h5678, 16'h9ABC);
		send_op(OP_INSERT, '0, '1, '1, '1);
		send_op(OP_FIND, '0, '1, '1, '1);
		send_op(OP_FIND, '1, '0, '0, '0);
		send_op(OP_FIND, 32'h8000_0000, '0, '0, '0);
		send_op(OP_FIND, 32'd1, '0, '0, '0);
		send_op(OP_UNUSED, '0, '0, '0, '0);
		send_op(OP_DELETE, 32'h8000_0000, '0, '0, '0);
		send_op(OP_DELETE, '1, '0, '0, '0);
		send_op(OP_DELETE, '0, '0, '0, '0);
		send_op(OP_DELETE, '0, '0, '0, '0);
		send_op(OP_FIND, 32'h7FFF_FFFF, '0, '0, '0);
		send_op(OP_DELETE, 32'h7FFF_FFFF, '0, '0, '0);
		send_op(OP_FIND, 32'h7FFF_FFFF, '0, '0, '0);
		wait_drained();
	endtask

	// fill to full, drain, then a balanced mix; sender pauses between phases
	task automatic test_fill_drain(input int send_pct, input int recv_pct);
		set_idling(send_pct, recv_pct);
		run_phase(200, 85, 8, 30);
		wait_drained();
		run_phase(170, 15, 70, 70);
		wait_drained();
		run_phase(100, 45, 35, 50);
		wait_drained();
	endtask

	task automatic test_backpressure;
		set_idling(0, 0);
		fork
			begin
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		run_phase(24, 50, 30, 50);
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_drain(0, 0);
		test_fill_drain(71, 0);
		test_fill_drain(0, 71);
		test_fill_drain(29, 29);
		test_backpressure();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d operations, %0d results; peak occupancy %0d, %0d full rejects",
			ops_sent, results_seen, peak_count, n_full);
		$display("%0d duplicates, %0d misses, %0d hits on find, %0d unused opcodes",
			n_dup, n_missing, n_found, n_unused);
		if (errors == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_ram.sv
hdl/skt_datapath.sv
hdl/skt_ctrl.sv
hdl/sorted_key_table.sv
test/sorted_key_table_test.sv
